// ----- rtl/core/bcsh_pkg.sv -----
// Shared widths for the swept ball cutter height pipeline.
package bcsh_pkg;

  localparam int CoordW = 24;                 // coordinate field width
  localparam int RadW   = 20;                 // tool radius register width
  localparam int DiffW  = CoordW + 1;         // coordinate differences
  localparam int SqW    = 2 * DiffW;          // product of two differences
  localparam int AW     = 2 * DiffW;          // A = dx^2 + dy^2, also L2
  localparam int PW     = 2 * DiffW + 1;      // signed P and Q
  localparam int PMW    = 2 * DiffW;          // |P|, |Q|
  localparam int R2W    = 2 * RadW;           // r^2
  localparam int Q2W    = 2 * PMW;            // Q^2
  localparam int R2AW   = R2W + AW;           // r^2 * A
  localparam int WW     = R2AW;               // W = r^2*A - Q^2
  localparam int LimW   = 2 * AW;             // A * L2, L2 * |P|
  localparam int DW     = WW + AW;            // D = W * L2
  localparam int SqrtW  = DW / 2;             // floor(sqrt(D))
  localparam int RemW   = SqrtW + 4;          // root remainder
  localparam int DzpW   = DiffW + PMW;        // |dz| * |P|, |N|
  localparam int NW     = DzpW + 1;           // signed N
  localparam int DzsW   = DiffW + SqrtW;      // |dz| * s
  localparam int TW     = LimW + 2;           // signed T
  localparam int QuoW   = CoordW + 2;         // quotient bits kept; more saturates
  localparam int DivW   = DzpW + 1;           // dividend and shifted divisor

  // wide multiplier built from 26x26 limbs
  localparam int LimbW     = 26;
  localparam int MulALimbs = 4;
  localparam int MulBLimbs = 2;
  localparam int MulAW     = LimbW * MulALimbs;
  localparam int MulBW     = LimbW * MulBLimbs;
  localparam int MulPW     = MulAW + MulBW;
  localparam int MulLat    = 3;

endpackage

// ----- rtl/core/ball_cutter_swept_height_core.sv -----
// Top level: swept ball cutter surface height over one grid point per item.
//
//   channel | handshake                     | payload
//   --------+-------------------------------+---------------------------------------
//   in      | in_valid_i / in_stall_o       | grid_x/y, seg_start_x/y/z, seg_end_x/y/z
//   out     | out_valid_o / out_stall_i     | hit, cut_height
//   cfg     | cfg_valid_i / cfg_ready_o     | cfg_data_i -> tool_radius
//
// One item per cycle while out_stall_i does not freeze the pipe; an accepted
// item passes 113 register stages before it shows on out_valid_o, most of them
// the 70 stage square root of the 140 bit D term and the 26 stage quotient divider.
// All stages advance together; when the output item is held by out_stall_i
// the whole pipe freezes and in_stall_o is raised, so nothing is lost.
// Reset clears the valid bits and loads tool_radius with 32768 (8.0).
// cfg_ready_o is always high; writes are expected only while the pipe is idle.
module ball_cutter_swept_height_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bcsh_pkg::CoordW-1:0]  grid_x_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  grid_y_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  seg_start_x_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  seg_start_y_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  seg_start_z_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  seg_end_x_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  seg_end_y_i,
  input  logic signed [bcsh_pkg::CoordW-1:0]  seg_end_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [bcsh_pkg::CoordW-1:0]  cut_height_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bcsh_pkg::RadW-1:0]           cfg_data_i
);
  import bcsh_pkg::*;

  // stage numbering, stage 1 registers the input item
  localparam int St4   = 4;                 // magnitudes, feeds first multipliers
  localparam int St8   = St4 + MulLat + 1;  // W and miss test
  localparam int StD   = St8 + MulLat;      // D ready
  localparam int StS   = StD + SqrtW;       // sqrt ready
  localparam int St82  = StS + 1;           // N
  localparam int St85  = StS + MulLat + 1;  // T, |N|
  localparam int St86  = St85 + 1;          // range test, divide start
  localparam int StQ   = St86 + QuoW;       // quotient ready
  localparam int StOut = StQ + 1;           // output register

  localparam int XLen = MulLat;
  localparam int YLen = StS - St8;
  localparam int ZLen = MulLat - 1;
  localparam int VLen = QuoW;

  localparam int FzW = QuoW + 2;
  localparam int ZW  = FzW + 1;
  localparam logic signed [ZW-1:0] ZMax = ZW'((1 << (CoordW - 1)) - 1);
  localparam logic signed [ZW-1:0] ZMin = -ZMax - ZW'(1);
  localparam logic [RadW-1:0] RadReset = RadW'(32768);

  typedef struct packed {
    logic                     ok;
    logic [AW-1:0]            a;
    logic [AW-1:0]            l2;
    logic                     pneg;
    logic                     dzneg;
    logic [DiffW-1:0]         dzm;
    logic signed [CoordW-1:0] sz;
  } x_side_t;

  typedef struct packed {
    logic                     ok;
    logic [AW-1:0]            a;
    logic                     pneg;
    logic                     dzneg;
    logic [DiffW-1:0]         dzm;
    logic signed [CoordW-1:0] sz;
    logic [LimW-1:0]          lim;
    logic [LimW-1:0]          lp;
    logic [DzpW-1:0]          dzp;
  } y_side_t;

  typedef struct packed {
    logic                     ok;
    logic [AW-1:0]            a;
    logic                     pneg;
    logic                     dzneg;
    logic signed [CoordW-1:0] sz;
    logic [LimW-1:0]          lim;
    logic [LimW-1:0]          lp;
    logic signed [NW-1:0]     n;
  } z_side_t;

  typedef struct packed {
    logic                     ok;
    logic                     big;
    logic                     nneg;
    logic signed [CoordW-1:0] sz;
  } v_side_t;

  // ---------------- handshake and config ----------------
  logic              adv;
  logic [StOut:1]    vld_q;
  logic [RadW-1:0]   rad_q;

  assign adv         = !(vld_q[StOut] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[StOut];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[StOut-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rad_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: differences ----------------
  logic signed [DiffW-1:0]  dx1_q, dy1_q, dz1_q, fx1_q, fy1_q;
  logic signed [CoordW-1:0] sz1_q;
  logic [RadW-1:0]          r1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q <= DiffW'(seg_end_x_i) - DiffW'(seg_start_x_i);
      dy1_q <= DiffW'(seg_end_y_i) - DiffW'(seg_start_y_i);
      dz1_q <= DiffW'(seg_end_z_i) - DiffW'(seg_start_z_i);
      fx1_q <= DiffW'(grid_x_i) - DiffW'(seg_start_x_i);
      fy1_q <= DiffW'(grid_y_i) - DiffW'(seg_start_y_i);
      sz1_q <= seg_start_z_i;
      r1_q  <= rad_q;
    end
  end

  // ---------------- stage 2: small products ----------------
  logic signed [SqW-1:0]    dxdx2_q, dydy2_q, dzdz2_q, dxfx2_q, dyfy2_q, dxfy2_q, dyfx2_q;
  logic [R2W-1:0]           r2_2_q;
  logic signed [DiffW-1:0]  dz2_q;
  logic signed [CoordW-1:0] sz2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dxdx2_q <= SqW'(dx1_q) * SqW'(dx1_q);
      dydy2_q <= SqW'(dy1_q) * SqW'(dy1_q);
      dzdz2_q <= SqW'(dz1_q) * SqW'(dz1_q);
      dxfx2_q <= SqW'(dx1_q) * SqW'(fx1_q);
      dyfy2_q <= SqW'(dy1_q) * SqW'(fy1_q);
      dxfy2_q <= SqW'(dx1_q) * SqW'(fy1_q);
      dyfx2_q <= SqW'(dy1_q) * SqW'(fx1_q);
      r2_2_q  <= R2W'(r1_q) * R2W'(r1_q);
      dz2_q   <= dz1_q;
      sz2_q   <= sz1_q;
    end
  end

  // ---------------- stage 3: A, L2, P, Q ----------------
  logic [AW-1:0]            a3_q, l2_3_q;
  logic signed [PW-1:0]     p3_q, q3_q;
  logic [R2W-1:0]           r2_3_q;
  logic signed [DiffW-1:0]  dz3_q;
  logic signed [CoordW-1:0] sz3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a3_q   <= $unsigned(dxdx2_q) + $unsigned(dydy2_q);
      l2_3_q <= $unsigned(dxdx2_q) + $unsigned(dydy2_q) + $unsigned(dzdz2_q);
      p3_q   <= PW'(dxfx2_q) + PW'(dyfy2_q);
      q3_q   <= PW'(dxfy2_q) - PW'(dyfx2_q);
      r2_3_q <= r2_2_q;
      dz3_q  <= dz2_q;
      sz3_q  <= sz2_q;
    end
  end

  // ---------------- stage 4: magnitudes ----------------
  logic [PMW-1:0]           pm4_q, qm4_q;
  logic [DiffW-1:0]         dzm4_q;
  logic                     pneg4_q, dzneg4_q, ok4_q;
  logic [AW-1:0]            a4_q, l2_4_q;
  logic [R2W-1:0]           r2_4_q;
  logic signed [CoordW-1:0] sz4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm4_q    <= p3_q[PW-1] ? PMW'(-p3_q) : PMW'(p3_q);
      qm4_q    <= q3_q[PW-1] ? PMW'(-q3_q) : PMW'(q3_q);
      dzm4_q   <= dz3_q[DiffW-1] ? DiffW'(-dz3_q) : DiffW'(dz3_q);
      pneg4_q  <= p3_q[PW-1];
      dzneg4_q <= dz3_q[DiffW-1];
      ok4_q    <= (a3_q != '0);   // vertical or zero length move never hits
      a4_q     <= a3_q;
      l2_4_q   <= l2_3_q;
      r2_4_q   <= r2_3_q;
      sz4_q    <= sz3_q;
    end
  end

  // ---------------- first multiplier group ----------------
  logic [MulPW-1:0] q2_p, r2a_p, lim_p, lp_p, dzp_p;

  bcsh_mul u_mul_q2 (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(qm4_q)), .b_i (MulBW'(qm4_q)), .p_o (q2_p)
  );
  bcsh_mul u_mul_r2a (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(a4_q)), .b_i (MulBW'(r2_4_q)), .p_o (r2a_p)
  );
  bcsh_mul u_mul_lim (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(a4_q)), .b_i (MulBW'(l2_4_q)), .p_o (lim_p)
  );
  bcsh_mul u_mul_lp (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(pm4_q)), .b_i (MulBW'(l2_4_q)), .p_o (lp_p)
  );
  bcsh_mul u_mul_dzp (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(pm4_q)), .b_i (MulBW'(dzm4_q)), .p_o (dzp_p)
  );

  x_side_t x_q [XLen];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= '{ok: ok4_q, a: a4_q, l2: l2_4_q, pneg: pneg4_q, dzneg: dzneg4_q,
                  dzm: dzm4_q, sz: sz4_q};
      for (int i = 1; i < XLen; i++) x_q[i] <= x_q[i-1];
    end
  end

  // ---------------- stage 8: W = r^2*A - Q^2 ----------------
  logic [Q2W-1:0]  q2_w;
  logic [R2AW-1:0] r2a_w;
  logic [WW-1:0]   w8_q;
  logic [AW-1:0]   l2_8_q;
  y_side_t         y8_q;
  x_side_t         xx;

  assign q2_w  = q2_p[Q2W-1:0];
  assign r2a_w = r2a_p[R2AW-1:0];
  assign xx    = x_q[XLen-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w8_q   <= r2a_w - q2_w[WW-1:0];
      l2_8_q <= xx.l2;
      // a tangent line (W = 0) still counts as a touch
      y8_q   <= '{ok: xx.ok && (q2_w <= Q2W'(r2a_w)), a: xx.a, pneg: xx.pneg,
                  dzneg: xx.dzneg, dzm: xx.dzm, sz: xx.sz,
                  lim: lim_p[LimW-1:0], lp: lp_p[LimW-1:0], dzp: dzp_p[DzpW-1:0]};
    end
  end

  // ---------------- D = W * L2, then s = floor(sqrt(D)) ----------------
  logic [MulPW-1:0] d_p;
  logic [SqrtW-1:0] root;

  bcsh_mul u_mul_d (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(w8_q)), .b_i (MulBW'(l2_8_q)), .p_o (d_p)
  );

  bcsh_sqrt u_sqrt (
    .clk_i (clk_i), .en_i (adv),
    .rad_i (d_p[DW-1:0]), .root_o (root)
  );

  y_side_t y_q [YLen];
  y_side_t yy;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q[0] <= y8_q;
      for (int i = 1; i < YLen; i++) y_q[i] <= y_q[i-1];
    end
  end

  assign yy = y_q[YLen-1];

  // ---------------- stage 82: N = dz*P - s, and dz*s product ----------------
  logic signed [NW-1:0] sdzp;
  z_side_t              z82_q;
  logic [MulPW-1:0]     dzs_p;

  assign sdzp = (yy.pneg ^ yy.dzneg) ? -$signed(NW'(yy.dzp)) : $signed(NW'(yy.dzp));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z82_q <= '{ok: yy.ok, a: yy.a, pneg: yy.pneg, dzneg: yy.dzneg, sz: yy.sz,
                 lim: yy.lim, lp: yy.lp, n: sdzp - $signed(NW'(root))};
    end
  end

  bcsh_mul u_mul_dzs (
    .clk_i (clk_i), .en_i (adv),
    .a_i   (MulAW'(root)), .b_i (MulBW'(yy.dzm)), .p_o (dzs_p)
  );

  z_side_t z_q [ZLen];
  z_side_t zz;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z_q[0] <= z82_q;
      for (int i = 1; i < ZLen; i++) z_q[i] <= z_q[i-1];
    end
  end

  assign zz = z_q[ZLen-1];

  // ---------------- stage 85: T = L2*P - dz*s, |N| ----------------
  logic signed [TW-1:0] lp_s, dzs_s;
  logic signed [TW-1:0] t85_q;
  logic [DzpW-1:0]      nm85_q;
  logic                 nneg85_q, ok85_q;
  logic [AW-1:0]        a85_q;
  logic [LimW-1:0]      lim85_q;
  logic signed [CoordW-1:0] sz85_q;

  assign lp_s  = zz.pneg  ? -$signed(TW'(zz.lp)) : $signed(TW'(zz.lp));
  assign dzs_s = zz.dzneg ? -$signed(TW'(dzs_p[DzsW-1:0])) : $signed(TW'(dzs_p[DzsW-1:0]));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t85_q    <= lp_s - dzs_s;
      nm85_q   <= zz.n[NW-1] ? DzpW'(-zz.n) : DzpW'(zz.n);
      nneg85_q <= zz.n[NW-1];
      ok85_q   <= zz.ok;
      a85_q    <= zz.a;
      lim85_q  <= zz.lim;
      sz85_q   <= zz.sz;
    end
  end

  // ---------------- stage 86: segment range test, overflow test ----------------
  logic [DivW-1:0] num86_q;
  logic [AW-1:0]   a86_q;
  v_side_t         v86_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num86_q <= DivW'(nm85_q);
      a86_q   <= a85_q;
      // projection must land on the segment: 0 <= T <= A*L2
      v86_q   <= '{ok: ok85_q && !t85_q[TW-1] && ($unsigned(t85_q) <= TW'(lim85_q)),
                   big: (DivW'(nm85_q) >= (DivW'(a85_q) << QuoW)),
                   nneg: nneg85_q, sz: sz85_q};
    end
  end

  // ---------------- quotient |N| / A ----------------
  logic [QuoW-1:0] quo;
  logic            rem_nz;

  bcsh_div u_div (
    .clk_i (clk_i), .en_i (adv),
    .num_i (num86_q), .den_i (a86_q),
    .quo_o (quo), .rem_nz_o (rem_nz)
  );

  v_side_t v_q [VLen];
  v_side_t vv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_q[0] <= v86_q;
      for (int i = 1; i < VLen; i++) v_q[i] <= v_q[i-1];
    end
  end

  assign vv = v_q[VLen-1];

  // ---------------- output stage: floor, add start z, saturate ----------------
  logic [QuoW:0]            q1;
  logic signed [FzW-1:0]    fz;
  logic signed [ZW-1:0]     zsum;
  logic signed [CoordW-1:0] zsat;
  logic                     hit_q;
  logic signed [CoordW-1:0] cut_q;

  always_comb begin
    // negative N rounds toward minus infinity: bump the magnitude
    q1   = (QuoW+1)'(quo) + (QuoW+1)'(vv.nneg && rem_nz);
    fz   = vv.nneg ? -$signed(FzW'(q1)) : $signed(FzW'(q1));
    zsum = ZW'(vv.sz) + ZW'(fz);
    if (vv.big) begin
      zsat = vv.nneg ? CoordW'(ZMin) : CoordW'(ZMax);
    end else if (zsum > ZMax) begin
      zsat = CoordW'(ZMax);
    end else if (zsum < ZMin) begin
      zsat = CoordW'(ZMin);
    end else begin
      zsat = CoordW'(zsum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= vv.ok;
      cut_q <= vv.ok ? zsat : '0;
    end
  end

  assign hit_o        = hit_q;
  assign cut_height_o = cut_q;

  // ---------------- checks ----------------
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output item");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (cut_height_o == '0))
    else $error("miss item carries a nonzero height");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (vld_q[1] == $past(in_valid_i)))
    else $error("accepted item not tracked in stage one");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule

// ----- rtl/core/bcsh_mul.sv -----
// Three stage unsigned multiplier from limb partial products.
module bcsh_mul (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [bcsh_pkg::MulAW-1:0]   a_i,
  input  logic [bcsh_pkg::MulBW-1:0]   b_i,
  output logic [bcsh_pkg::MulPW-1:0]   p_o
);
  import bcsh_pkg::*;

  localparam int PpW  = 2 * LimbW;
  localparam int RowW = MulAW + LimbW;

  logic [PpW-1:0]   pp_q  [MulALimbs*MulBLimbs];
  logic [RowW-1:0]  row_d [MulBLimbs];
  logic [RowW-1:0]  row_q [MulBLimbs];
  logic [MulPW-1:0] p_d;
  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < MulALimbs; i++) begin
        for (int j = 0; j < MulBLimbs; j++) begin
          pp_q[i*MulBLimbs+j] <= PpW'(a_i[i*LimbW +: LimbW]) * PpW'(b_i[j*LimbW +: LimbW]);
        end
      end
    end
  end

  // even and odd limbs do not overlap, so each row is one add
  always_comb begin
    logic [RowW-1:0] ev;
    logic [RowW-1:0] od;
    for (int j = 0; j < MulBLimbs; j++) begin
      ev = '0;
      od = '0;
      for (int i = 0; i < MulALimbs; i++) begin
        if (i % 2 == 0) ev = ev | (RowW'(pp_q[i*MulBLimbs+j]) << (i*LimbW));
        else            od = od | (RowW'(pp_q[i*MulBLimbs+j]) << (i*LimbW));
      end
      row_d[j] = ev + od;
    end
  end

  always_comb begin
    p_d = '0;
    for (int j = 0; j < MulBLimbs; j++) begin
      p_d = p_d + (MulPW'(row_q[j]) << (j*LimbW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/bcsh_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module bcsh_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [bcsh_pkg::DW-1:0]      rad_i,
  output logic [bcsh_pkg::SqrtW-1:0]   root_o
);
  import bcsh_pkg::*;

  logic [DW-1:0]    rad_q  [SqrtW];
  logic [RemW-1:0]  rem_q  [SqrtW];
  logic [SqrtW-1:0] root_q [SqrtW];

  for (genvar k = 0; k < SqrtW; k++) begin : g_step
    logic [DW-1:0]    rad_in;
    logic [RemW-1:0]  rem_in;
    logic [SqrtW-1:0] root_in;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[RemW-3:0], rad_in[DW-1 -: 2]};
    assign trial  = RemW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[SqrtW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[SqrtW-1];

endmodule

// ----- rtl/core/bcsh_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module bcsh_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [bcsh_pkg::DivW-1:0]    num_i,
  input  logic [bcsh_pkg::AW-1:0]      den_i,
  output logic [bcsh_pkg::QuoW-1:0]    quo_o,
  output logic                         rem_nz_o
);
  import bcsh_pkg::*;

  logic [DivW-1:0] num_q [QuoW];
  logic [AW-1:0]   den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DivW-1:0] num_in;
    logic [AW-1:0]   den_in;
    logic [QuoW-1:0] quo_in;
    logic [DivW-1:0] sd;
    logic            ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign sd = DivW'(den_in) << (QuoW - 1 - k);
    assign ge = (num_in >= sd);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= ge ? (num_in - sd) : num_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QuoW-2:0], ge};
      end
    end
  end

  assign quo_o    = quo_q[QuoW-1];
  assign rem_nz_o = |num_q[QuoW-1];

endmodule
